@@ hw/rtl/hsl2rgb_pkg.sv @@
// shared types and constants for the hsl to rgb converter
// no dependencies; imported by every module of the block

package hsl2rgb_pkg;

    // pipeline stages between an accepted start and its done strobe
    localparam int LATENCY = 7;

    // hue is in 1/16 degree: 960 per sector, six sectors per turn
    localparam logic [9:0]         HUE_SECTOR = 10'd960;
    // six turns, lifts any 16-bit signed hue to a positive value
    localparam logic signed [17:0] HUE_OFFSET = 18'sd34560;
    // floor(2^26 / 960), quotient is exact or one low
    localparam logic [16:0]        HUE_RECIP  = 17'd69905;
    localparam int                 HUE_SHIFT  = 26;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t    sec;
        logic [9:0] pos;
    } hue_pos_t;

endpackage

@@ hw/rtl/hsl2rgb_hue_split.sv @@
// hue wrap and split into sector and in-sector position, four stages
// depends on hsl2rgb_pkg

module hsl2rgb_hue_split
    import hsl2rgb_pkg::*;
(
    input  logic              clk,
    input  logic signed [15:0] hue,
    output hue_pos_t          hpos
);

    logic [16:0]      u_next;
    logic [16:0]      u_reg;
    logic [16:0]      u2_reg;
    logic [32:0]      qprod_next;
    logic [32:0]      qprod_reg;
    logic [6:0]       q0;
    logic [16:0]      r0;
    logic [6:0]       q_next;
    logic [6:0]       q_reg;
    logic [9:0]       pos_next;
    logic [9:0]       pos_reg;
    logic [12:0]      q43;
    logic [6:0]       sec_raw;
    hue_pos_t         hpos_next;
    hue_pos_t         hpos_reg;

    // stage 1: positive hue, same sector and position
    assign u_next = 17'(18'(hue) + HUE_OFFSET);

    // stage 2: reciprocal multiply by 1/960
    assign qprod_next = 33'(u_reg * HUE_RECIP);

    // stage 3: one correction step
    always_comb
    begin
        q0 = qprod_reg[HUE_SHIFT+6:HUE_SHIFT];
        r0 = u2_reg - 17'(q0 * HUE_SECTOR);
        if (r0 >= 17'(HUE_SECTOR))
        begin
            q_next   = q0 + 7'd1;
            pos_next = 10'(r0 - 17'(HUE_SECTOR));
        end
        else
        begin
            q_next   = q0;
            pos_next = r0[9:0];
        end
    end

    // stage 4: sector = quotient mod 6, floor(q/6) as (q*43)>>8
    always_comb
    begin
        q43           = 13'(q_reg * 6'd43);
        sec_raw       = q_reg - 7'(q43[12:8] * 3'd6);
        hpos_next.sec = sector_t'(sec_raw[2:0]);
        hpos_next.pos = pos_reg;
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        qprod_reg <= qprod_next;
        u2_reg    <= u_reg;
        q_reg     <= q_next;
        pos_reg   <= pos_next;
        hpos_reg  <= hpos_next;
    end

    assign hpos = hpos_reg;

endmodule

@@ hw/rtl/hsl2rgb_chroma.sv @@
// chroma = (1 - |2l - 1|) * s in four stages, lightness carried along
// depends on hsl2rgb_pkg

module hsl2rgb_chroma
    import hsl2rgb_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  logic                    clk,
    input  logic [CHANNEL_BITS-1:0] saturation,
    input  logic [CHANNEL_BITS-1:0] lightness,
    output logic [CHANNEL_BITS-1:0] chroma,
    output logic [CHANNEL_BITS:0]   two_l
);

    localparam int CB = CHANNEL_BITS;
    localparam logic [CB:0] FULL = {1'b0, {CB{1'b1}}};

    logic [CB:0]     tl_in;
    logic [CB:0]     dev;
    logic [CB-1:0]   span_next;
    logic [CB-1:0]   span_reg;
    logic [CB-1:0]   s_reg;
    logic [2*CB-1:0] prod_next;
    logic [2*CB-1:0] prod_reg;
    logic [2*CB:0]   qsum;
    logic [CB-1:0]   c_next;
    logic [CB-1:0]   c3_reg;
    logic [CB-1:0]   c4_reg;
    logic [CB-1:0]   l1_reg;
    logic [CB-1:0]   l2_reg;
    logic [CB-1:0]   l3_reg;
    logic [CB-1:0]   l4_reg;

    // stage 1: span = full - |2l - full|
    always_comb
    begin
        tl_in     = {lightness, 1'b0};
        dev       = (tl_in >= FULL) ? (tl_in - FULL) : (FULL - tl_in);
        span_next = CB'(FULL - dev);
    end

    // stage 2: span * s
    assign prod_next = (2*CB)'(span_reg * s_reg);

    // stage 3: divide by 2^CB - 1 as (p + (p >> CB) + 1) >> CB
    always_comb
    begin
        qsum   = {1'b0, prod_reg} + (2*CB+1)'(prod_reg >> CB) + (2*CB+1)'(1);
        c_next = qsum[2*CB-1:CB];
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
        s_reg    <= saturation;
        l1_reg   <= lightness;
        prod_reg <= prod_next;
        l2_reg   <= l1_reg;
        c3_reg   <= c_next;
        l3_reg   <= l2_reg;
        c4_reg   <= c3_reg;
        l4_reg   <= l3_reg;
    end

    assign chroma = c4_reg;
    assign two_l  = {l4_reg, 1'b0};

endmodule

@@ hw/rtl/hsl2rgb_mix.sv @@
// intermediate component, sector permutation, offset and clamp, three stages
// depends on hsl2rgb_pkg

module hsl2rgb_mix
    import hsl2rgb_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  logic                    clk,
    input  hue_pos_t                hpos,
    input  logic [CHANNEL_BITS-1:0] chroma,
    input  logic [CHANNEL_BITS:0]   two_l,
    output logic [CHANNEL_BITS-1:0] red,
    output logic [CHANNEL_BITS-1:0] green,
    output logic [CHANNEL_BITS-1:0] blue
);

    localparam int CB  = CHANNEL_BITS;
    // exact divide by 15 for values below 2^(CB+4)
    localparam int W15 = CB + 8;
    localparam longint unsigned R15_L = ((64'd1 << W15) + 64'd14) / 64'd15;
    localparam logic [CB+4:0] R15 = R15_L[CB+4:0];
    localparam logic [CB-1:0] FULL = {CB{1'b1}};

    function automatic logic [CB-1:0] channel(input logic [CB-1:0] comp,
                                              input logic [CB:0]   m2);
        logic [CB+1:0] sum;
        logic [CB:0]   half;
        sum  = {1'b0, comp, 1'b0} + {1'b0, m2};
        half = sum[CB+1:1];
        return half[CB] ? FULL : half[CB-1:0];
    endfunction

    logic [9:0]       k;
    logic [CB+9:0]    kprod_next;
    logic [CB+9:0]    kprod_reg;
    logic [CB-1:0]    c5_reg;
    logic [CB-1:0]    c6_reg;
    sector_t          sec5_reg;
    sector_t          sec6_reg;
    logic [CB:0]      tl5_reg;
    logic [CB:0]      tl6_reg;
    logic [CB+3:0]    v;
    logic [2*CB+8:0]  rprod_next;
    logic [2*CB+8:0]  rprod_reg;
    logic [CB-1:0]    x;
    logic [CB:0]      m2;
    logic [CB-1:0]    r_c;
    logic [CB-1:0]    g_c;
    logic [CB-1:0]    b_c;
    logic [CB-1:0]    red_next;
    logic [CB-1:0]    green_next;
    logic [CB-1:0]    blue_next;
    logic [CB-1:0]    red_reg;
    logic [CB-1:0]    green_reg;
    logic [CB-1:0]    blue_reg;

    // stage 5: c * pos, or c * (960 - pos) in odd sectors
    always_comb
    begin
        k          = hpos.sec[0] ? (HUE_SECTOR - hpos.pos) : hpos.pos;
        kprod_next = (CB+10)'(chroma * k);
    end

    // stage 6: /960 = >>6 then /15 by reciprocal
    always_comb
    begin
        v          = kprod_reg[CB+9:6];
        rprod_next = (2*CB+9)'(v * R15);
    end

    // stage 7: permute, add offset 2l - c, halve, clamp
    always_comb
    begin
        x  = rprod_reg[W15+CB-1:W15];
        m2 = (tl6_reg >= {1'b0, c6_reg}) ? (tl6_reg - {1'b0, c6_reg}) : '0;
        r_c = '0;
        g_c = '0;
        b_c = '0;
        unique case (sec6_reg)
            SEC_R_TO_Y:
            begin
                r_c = c6_reg;
                g_c = x;
            end
            SEC_Y_TO_G:
            begin
                r_c = x;
                g_c = c6_reg;
            end
            SEC_G_TO_C:
            begin
                g_c = c6_reg;
                b_c = x;
            end
            SEC_C_TO_B:
            begin
                g_c = x;
                b_c = c6_reg;
            end
            SEC_B_TO_M:
            begin
                r_c = x;
                b_c = c6_reg;
            end
            default:
            begin
                r_c = c6_reg;
                b_c = x;
            end
        endcase
        red_next   = channel(r_c, m2);
        green_next = channel(g_c, m2);
        blue_next  = channel(b_c, m2);
    end

    always_ff @(posedge clk)
    begin
        kprod_reg <= kprod_next;
        c5_reg    <= chroma;
        sec5_reg  <= hpos.sec;
        tl5_reg   <= two_l;
        rprod_reg <= rprod_next;
        c6_reg    <= c5_reg;
        sec6_reg  <= sec5_reg;
        tl6_reg   <= tl5_reg;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

@@ hw/rtl/hsl_to_rgb_converter.sv @@
// top level of the hsl to rgb converter: hue split, chroma and mix pipelines
// depends on hsl2rgb_pkg, hsl2rgb_hue_split, hsl2rgb_chroma, hsl2rgb_mix
//
// channel   handshake         payload
// -------   ---------------   ------------------------------------------
// input     start / busy      hue, saturation, lightness, alpha_in
// result    done (strobe)     red, green, blue, alpha_out
//
// one beat in per clock, one result beat out per clock
// the latency is set by the seven register stages of the pipeline
// busy is always low: the pipeline never holds off a start
// reset clears only the valid bits; no result strobes until fed
// done lasts one cycle per beat, the receiver has no way to stall it

module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
#(
    parameter int CHANNEL_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [15:0]      hue,
    input  logic [CHANNEL_BITS-1:0] saturation,
    input  logic [CHANNEL_BITS-1:0] lightness,
    input  logic [CHANNEL_BITS-1:0] alpha_in,
    output logic                    done,
    output logic [CHANNEL_BITS-1:0] red,
    output logic [CHANNEL_BITS-1:0] green,
    output logic [CHANNEL_BITS-1:0] blue,
    output logic [CHANNEL_BITS-1:0] alpha_out
);

    logic                    accept;
    logic [LATENCY-1:0]      vld_reg;
    logic [LATENCY-1:0]      vld_next;
    logic [CHANNEL_BITS-1:0] alpha_reg [LATENCY];
    hue_pos_t                hpos;
    logic [CHANNEL_BITS-1:0] chroma;
    logic [CHANNEL_BITS:0]   two_l;

    // fully pipelined, every start is taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid bits travel beside the datapath stages
    assign vld_next = {vld_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // alpha rides a plain delay line matching the datapath depth
    always_ff @(posedge clk)
    begin
        alpha_reg[0] <= alpha_in;
        for (int i = 1; i < LATENCY; i++)
        begin
            alpha_reg[i] <= alpha_reg[i-1];
        end
    end

    // stages 1-4: wrapped hue into sector and position
    hsl2rgb_hue_split u_hue_split (
        .clk  (clk),
        .hue  (hue),
        .hpos (hpos)
    );

    // stages 1-4: chroma and doubled lightness
    hsl2rgb_chroma #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_chroma (
        .clk        (clk),
        .saturation (saturation),
        .lightness  (lightness),
        .chroma     (chroma),
        .two_l      (two_l)
    );

    // stages 5-7: intermediate component, permutation and output registers
    hsl2rgb_mix #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mix (
        .clk    (clk),
        .hpos   (hpos),
        .chroma (chroma),
        .two_l  (two_l),
        .red    (red),
        .green  (green),
        .blue   (blue)
    );

    assign done      = vld_reg[LATENCY-1];
    assign alpha_out = alpha_reg[LATENCY-1];

    // every accepted beat comes out as a done strobe at the end of the pipeline
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted beat did not produce a result");

    // no result without a matching beat
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without an accepted beat");

    // zero saturation gives a gray equal to the lightness
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && saturation == '0) |-> ##LATENCY
            (red == $past(lightness, LATENCY) && green == red && blue == red))
        else $error("gray input did not give equal channels");

endmodule
